// ===== design/ssp_pkg.sv =====
package ssp_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int TICK_BITS  = 16;
  localparam int PROD_BITS  = ANGLE_BITS + TICK_BITS;

  // The step counter must cover the longer of the two serial passes.
  localparam int STEP_MAX  = (TICK_BITS > ANGLE_BITS) ? TICK_BITS : ANGLE_BITS;
  localparam int CNT_BITS  = $clog2(STEP_MAX);

  localparam int NUM_REGS     = 4;
  localparam int REG_IDX_BITS = $clog2(NUM_REGS);
  localparam int PADDR_BITS   = REG_IDX_BITS + 2;
  localparam int PDATA_BITS   = 32;

  localparam logic [REG_IDX_BITS-1:0] REG_MIN_TICKS = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_TICKS = REG_IDX_BITS'(1);
  localparam logic [REG_IDX_BITS-1:0] REG_MAX_ANGLE = REG_IDX_BITS'(2);
  localparam logic [REG_IDX_BITS-1:0] REG_STEP_SIZE = REG_IDX_BITS'(3);

  localparam logic [TICK_BITS-1:0]  MIN_TICKS_RST = TICK_BITS'(400);
  localparam logic [TICK_BITS-1:0]  MAX_TICKS_RST = TICK_BITS'(1075);
  localparam logic [ANGLE_BITS-1:0] MAX_ANGLE_RST = ANGLE_BITS'(1350);
  localparam logic [ANGLE_BITS-1:0] STEP_SIZE_RST = ANGLE_BITS'(20);

  typedef struct packed {
    logic [TICK_BITS-1:0]  min_ticks;
    logic [TICK_BITS-1:0]  max_ticks;
    logic [ANGLE_BITS-1:0] max_angle;
    logic [ANGLE_BITS-1:0] step_size;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle;
    logic                  at_target;
  } slew_res_t;

endpackage

// ===== design/ssp_in_if.sv =====
interface ssp_in_if;
  import ssp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] target_angle;

  modport source (output valid, output target_angle, input ready);
  modport sink   (input valid, input target_angle, output ready);
endinterface

// ===== design/ssp_out_if.sv =====
interface ssp_out_if;
  import ssp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [TICK_BITS-1:0]  pwm_value;
  logic [ANGLE_BITS-1:0] current_angle_out;
  logic                  at_target;

  modport source (output valid, output pwm_value, output current_angle_out,
                  output at_target, input ready);
  modport sink   (input valid, input pwm_value, input current_angle_out,
                  input at_target, output ready);
endinterface

// ===== design/ssp_regs.sv =====
module ssp_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssp_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [ssp_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [ssp_pkg::PDATA_BITS-1:0]  prdata,
  output logic                            pready,
  output ssp_pkg::cfg_t                   cfg_o
);
  import ssp_pkg::*;

  cfg_t                    cfg_q;
  logic                    wr_en;
  logic [REG_IDX_BITS-1:0] idx;

  assign idx    = paddr[PADDR_BITS-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_ticks <= MIN_TICKS_RST;
      cfg_q.max_ticks <= MAX_TICKS_RST;
      cfg_q.max_angle <= MAX_ANGLE_RST;
      cfg_q.step_size <= STEP_SIZE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_TICKS: cfg_q.min_ticks <= pwdata[TICK_BITS-1:0];
        REG_MAX_TICKS: cfg_q.max_ticks <= pwdata[TICK_BITS-1:0];
        REG_MAX_ANGLE: cfg_q.max_angle <= pwdata[ANGLE_BITS-1:0];
        REG_STEP_SIZE: cfg_q.step_size <= pwdata[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_TICKS: prdata = PDATA_BITS'(cfg_q.min_ticks);
      REG_MAX_TICKS: prdata = PDATA_BITS'(cfg_q.max_ticks);
      REG_MAX_ANGLE: prdata = PDATA_BITS'(cfg_q.max_angle);
      REG_STEP_SIZE: prdata = PDATA_BITS'(cfg_q.step_size);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== design/ssp_slew.sv =====
module ssp_slew (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [ssp_pkg::ANGLE_BITS-1:0]  target_i,
  input  logic [ssp_pkg::ANGLE_BITS-1:0]  step_size_i,
  output ssp_pkg::slew_res_t              res_o
);
  import ssp_pkg::*;

  logic [ANGLE_BITS-1:0] cur_q, cur_d;
  logic                  at_q;
  logic [ANGLE_BITS-1:0] diff;
  logic                  below;

  // Move toward the target, landing on it when it is within one step.
  always_comb begin
    below = cur_q < target_i;
    diff  = below ? (target_i - cur_q) : (cur_q - target_i);
    if (diff <= step_size_i) begin
      cur_d = target_i;
    end else if (below) begin
      cur_d = cur_q + step_size_i;
    end else begin
      cur_d = cur_q - step_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      at_q  <= 1'b0;
    end else if (step_i) begin
      cur_q <= cur_d;
      at_q  <= (cur_d == target_i);
    end
  end

  assign res_o.angle     = cur_q;
  assign res_o.at_target = at_q;

endmodule

// ===== design/ssp_map.sv =====
module ssp_map (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ssp_pkg::ANGLE_BITS-1:0]  angle_i,
  input  ssp_pkg::cfg_t                   cfg_i,
  output logic                            busy_o,
  output logic [ssp_pkg::TICK_BITS-1:0]   pwm_o
);
  import ssp_pkg::*;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;

  logic [1:0]            phase_q, phase_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [TICK_BITS-1:0]  span_q, span_d;
  logic [ANGLE_BITS-1:0] mplier_q, mplier_d;
  logic [PROD_BITS-1:0]  acc_q, acc_d;
  logic [ANGLE_BITS-1:0] rem_q, rem_d;
  logic [TICK_BITS-1:0]  res_q, res_d;

  logic [PROD_BITS-1:0]  mul_nxt;
  logic [ANGLE_BITS:0]   trial;
  logic                  fits;
  logic [ANGLE_BITS-1:0] rem_nxt;
  logic [TICK_BITS-1:0]  quo_nxt;

  // Multiply: one multiplier bit per cycle, MSB first.
  // Divide: restoring, one quotient bit per cycle. The quotient is below the
  // span, so only its low TICK_BITS bits are developed; the upper product bits
  // seed the remainder and are already below max_angle.
  always_comb begin
    mul_nxt = {acc_q[PROD_BITS-2:0], 1'b0} +
              (mplier_q[ANGLE_BITS-1] ? PROD_BITS'(span_q) : '0);
    trial   = {rem_q, acc_q[TICK_BITS-1]};
    fits    = trial >= {1'b0, cfg_i.max_angle};
    rem_nxt = fits ? ANGLE_BITS'(trial - {1'b0, cfg_i.max_angle})
                   : trial[ANGLE_BITS-1:0];
    quo_nxt = {acc_q[TICK_BITS-2:0], fits};
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    span_d   = span_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    res_d    = res_q;
    case (phase_q)
      P_IDLE: begin
        if (start_i) begin
          if (cfg_i.max_ticks < cfg_i.min_ticks) begin
            res_d = cfg_i.min_ticks;
          end else if (angle_i >= cfg_i.max_angle) begin
            // A zero full scale also lands here.
            res_d = cfg_i.max_ticks;
          end else begin
            span_d   = cfg_i.max_ticks - cfg_i.min_ticks;
            mplier_d = angle_i;
            acc_d    = '0;
            cnt_d    = CNT_BITS'(ANGLE_BITS - 1);
            phase_d  = P_MUL;
          end
        end
      end
      P_MUL: begin
        acc_d    = mul_nxt;
        mplier_d = {mplier_q[ANGLE_BITS-2:0], 1'b0};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_d   = mul_nxt[PROD_BITS-1:TICK_BITS];
          cnt_d   = CNT_BITS'(TICK_BITS - 1);
          phase_d = P_DIV;
        end
      end
      P_DIV: begin
        rem_d                  = rem_nxt;
        acc_d[TICK_BITS-1:0]   = quo_nxt;
        cnt_d                  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          res_d   = cfg_i.min_ticks + quo_nxt;
          phase_d = P_IDLE;
        end
      end
      default: phase_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q   <= span_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    res_q    <= res_d;
  end

  assign busy_o = (phase_q != P_IDLE);
  assign pwm_o  = res_q;

endmodule

// ===== design/servo_slew_pwm_generator.sv =====
// Servo slew limiter and PWM compare generator.
//
// Items arrive on in_i, one per servo frame, each with a target angle in
// tenths of a degree. The block steps its current angle toward the target by
// at most step_size and then maps it linearly onto the range min_ticks to
// max_ticks. One result item leaves on out_o for every input item, carrying
// the compare value, the new angle and an at-target flag.
// Registers are to be written by the user over the APB port only while the
// block is idle; the block itself does not enforce this. pready is always
// high and reads return the stored values. The mapping runs a bit-serial
// multiply and then a restoring divide on one shared shift datapath;
// saturated and inverted ranges skip both. One item is worked on at a time:
// in_i is ready again once the result sits in the output register, even if
// the receiver has not taken it yet; a stalled receiver then holds the next
// result inside the block.
// Reset brings the angle to zero and the registers to their defaults.
module servo_slew_pwm_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ssp_in_if.sink                          in_i,
  ssp_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssp_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [ssp_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [ssp_pkg::PDATA_BITS-1:0]  prdata,
  output logic                            pready
);
  import ssp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  cfg_t                  cfg;
  slew_res_t             slew_res;
  logic                  in_acc;
  logic                  map_start;
  logic                  map_busy;
  logic [TICK_BITS-1:0]  map_pwm;
  logic                  out_free;
  logic                  out_load;

  logic [1:0]            state_q, state_d;
  logic                  out_valid_q;
  logic [TICK_BITS-1:0]  pwm_q;
  logic [ANGLE_BITS-1:0] angle_q;
  logic                  at_q;

  ssp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssp_slew u_slew (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_acc),
    .target_i    (in_i.target_angle),
    .step_size_i (cfg.step_size),
    .res_o       (slew_res)
  );

  ssp_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (map_start),
    .angle_i (slew_res.angle),
    .cfg_i   (cfg),
    .busy_o  (map_busy),
    .pwm_o   (map_pwm)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign map_start  = (state_q == ST_START);
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == ST_RUN) && !map_busy && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc)   state_d = ST_START;
      ST_START: state_d = ST_RUN;
      ST_RUN:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pwm_q   <= map_pwm;
      angle_q <= slew_res.angle;
      at_q    <= slew_res.at_target;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.pwm_value         = pwm_q;
  assign out_o.current_angle_out = angle_q;
  assign out_o.at_target         = at_q;

endmodule
